// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold whenever the antecedent holds, outside reset.
`define QNC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Expression must never be true, outside reset.
`define QNC_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/qnc_pkg.sv =====
// Shared constants, types and codes for the quaternion normalizer.
package qnc_pkg;

    localparam int IN_W      = 16;
    localparam int FRAC_BITS = 14;
    localparam int OUT_W     = FRAC_BITS + 2;
    localparam int MANT_BITS = 30;
    localparam int QUO_BITS  = FRAC_BITS + 1;
    localparam int ROOT_STEPS = 32;

    localparam logic [1:0] REG_FORCE_W    = 2'd0;
    localparam logic [1:0] REG_CONTINUITY = 2'd1;
    localparam logic [1:0] REG_SENTINEL   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_SQ, ST_ROOT, ST_DIV, ST_DOT, ST_FIN, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_REJECT, OP_NORM, OP_SQ, OP_ROOT, OP_DIV, OP_DOT, OP_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] comp;
        logic [4:0] step;
    } cmd_t;

    typedef struct packed {
        logic reject;
    } status_t;

endpackage

// ===== hw/rtl/qnc_ctrl.sv =====
// Sequencer that steps the datapath through one request at a time.
module qnc_ctrl import qnc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] comp_reg, comp_next;
    logic [4:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            comp_reg  <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        comp_next  = comp_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.comp   = comp_reg;
        cmd.step   = step_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.reject) begin
                    cmd.op     = OP_REJECT;
                    state_next = ST_OUT;
                end else begin
                    cmd.op     = OP_NORM;
                    comp_next  = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.op    = OP_SQ;
                comp_next = comp_reg + 2'd1;
                if (comp_reg == 2'd3) begin
                    step_next  = 5'(ROOT_STEPS - 1);
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.op    = OP_ROOT;
                step_next = step_reg - 5'd1;
                if (step_reg == '0) begin
                    comp_next  = '0;
                    step_next  = 5'(QUO_BITS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (step_reg == '0) begin
                    comp_next = comp_reg + 2'd1;
                    step_next = 5'(QUO_BITS - 1);
                    if (comp_reg == 2'd3) begin
                        state_next = ST_DOT;
                    end
                end else begin
                    step_next = step_reg - 5'd1;
                end
            end
            ST_DOT: begin
                cmd.op    = OP_DOT;
                comp_next = comp_reg + 2'd1;
                if (comp_reg == 2'd3) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.op     = OP_FIN;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/qnc_dp.sv =====
// Datapath: scaling, shared square-root and divider iterations, sign alignment.
module qnc_dp import qnc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic [4*IN_W-1:0] in_data,
    input  cmd_t             cmd,
    output status_t          status,
    output logic [4*OUT_W-1:0] out_data,
    output logic             out_accepted
);

    logic                       force_w_reg, cont_reg;
    logic signed [IN_W-1:0]     sentinel_reg;
    logic signed [IN_W-1:0]     vin_reg [4];
    logic [MANT_BITS-1:0]       a_reg [4];
    logic [3:0]                 neg_reg;
    logic [63:0]                rem_reg, root_reg;
    logic [31:0]                drem_reg;
    logic [QUO_BITS-1:0]        q_reg [4];
    logic signed [33:0]         dot_reg;
    logic signed [OUT_W-1:0]    prev_reg [4];
    logic                       have_prev_reg;
    logic signed [OUT_W-1:0]    out_reg [4];
    logic                       acc_reg;

    logic [IN_W-1:0]            mag [4];
    logic [IN_W-1:0]            mag_max;
    logic [4:0]                 blen;
    logic [4:0]                 shamt;
    logic                       all_zero, all_sent;
    logic signed [OUT_W-1:0]    res [4];
    logic [59:0]                sq_prod;
    logic [63:0]                bitv, trial;
    logic [44:0]                num;
    logic [31:0]                dr_start;
    logic [32:0]                dtrial;
    logic                       dge;
    logic signed [31:0]         dot_prod;
    logic                       flip;

    always_comb begin
        all_zero = 1'b1;
        all_sent = 1'b1;
        mag_max  = '0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = vin_reg[i][IN_W-1] ? IN_W'(-vin_reg[i]) : IN_W'(vin_reg[i]);
            if (vin_reg[i] != '0) all_zero = 1'b0;
            if (vin_reg[i] != sentinel_reg) all_sent = 1'b0;
            if (mag[i] > mag_max) mag_max = mag[i];
        end
        blen = '0;
        for (int k = 0; k < IN_W; k++) begin
            if (mag_max[k]) blen = 5'(k + 1);
        end
        shamt = 5'(MANT_BITS) - blen;
        for (int i = 0; i < 4; i++) begin
            res[i] = neg_reg[i] ? OUT_W'(-$signed({1'b0, q_reg[i]}))
                                : $signed({1'b0, q_reg[i]});
        end
    end

    assign status.reject = all_zero || all_sent;

    assign sq_prod = a_reg[cmd.comp] * a_reg[cmd.comp];
    assign bitv    = 64'd1 << {cmd.step, 1'b0};
    assign trial   = root_reg + bitv;

    // Rounded numerator a * 2^FRAC_BITS + floor(n / 2); quotient fits QUO_BITS.
    assign num      = {1'b0, a_reg[cmd.comp], FRAC_BITS'(0)} + 45'(root_reg[31:1]);
    assign dr_start = (cmd.step == 5'(QUO_BITS - 1)) ? 32'(num[44:QUO_BITS]) : drem_reg;
    assign dtrial   = {dr_start, num[cmd.step[3:0]]};
    assign dge      = dtrial >= {1'b0, root_reg[31:0]};

    assign dot_prod = res[cmd.comp] * prev_reg[cmd.comp];

    assign flip = (cont_reg && have_prev_reg) ? (dot_reg < 0)
                                              : (force_w_reg && res[3] < 0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            force_w_reg   <= 1'b0;
            cont_reg      <= 1'b0;
            sentinel_reg  <= -16'sd1;
            have_prev_reg <= 1'b0;
            for (int i = 0; i < 4; i++) prev_reg[i] <= '0;
        end else begin
            if (cfg_valid && (cfg_index == REG_FORCE_W || cfg_index == REG_CONTINUITY ||
                              cfg_index == REG_SENTINEL)) begin
                have_prev_reg <= 1'b0;
                for (int i = 0; i < 4; i++) prev_reg[i] <= '0;
                case (cfg_index)
                    REG_FORCE_W:    force_w_reg  <= cfg_data[0];
                    REG_CONTINUITY: cont_reg     <= cfg_data[0];
                    REG_SENTINEL:   sentinel_reg <= $signed(cfg_data);
                    default: ;
                endcase
            end else if (cmd.op == OP_FIN) begin
                have_prev_reg <= 1'b1;
                for (int i = 0; i < 4; i++) prev_reg[i] <= flip ? OUT_W'(-res[i]) : res[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                for (int i = 0; i < 4; i++) vin_reg[i] <= $signed(in_data[i*IN_W +: IN_W]);
            end
            OP_REJECT: begin
                for (int i = 0; i < 4; i++) out_reg[i] <= '0;
                acc_reg <= 1'b0;
            end
            OP_NORM: begin
                for (int i = 0; i < 4; i++) begin
                    a_reg[i]   <= MANT_BITS'(mag[i]) << shamt;
                    neg_reg[i] <= vin_reg[i][IN_W-1];
                end
                rem_reg  <= '0;
                root_reg <= '0;
                dot_reg  <= '0;
            end
            OP_SQ: begin
                rem_reg <= rem_reg + 64'(sq_prod);
            end
            OP_ROOT: begin
                if (rem_reg >= trial) begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bitv;
                end else begin
                    root_reg <= root_reg >> 1;
                end
            end
            OP_DIV: begin
                drem_reg <= dge ? 32'(dtrial - {1'b0, root_reg[31:0]}) : dtrial[31:0];
                q_reg[cmd.comp][cmd.step[3:0]] <= dge;
            end
            OP_DOT: begin
                dot_reg <= dot_reg + 34'(dot_prod);
            end
            OP_FIN: begin
                for (int i = 0; i < 4; i++) out_reg[i] <= flip ? OUT_W'(-res[i]) : res[i];
                acc_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign out_data     = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};
    assign out_accepted = acc_reg;

endmodule

// ===== hw/rtl/quaternion_normalize_continuity_unit.sv =====
// Top level of the quaternion normalizer with hemisphere alignment.
// A rejected request skips the square-root, divider and alignment steps. A new
// request is taken only once the result is taken; the 32-step square-root loop and
// the 60 steps of the shared one-bit-per-cycle divider dominate each request.
// Reset (aresetn low, synchronous) clears the sequencer, config and stored history.
`include "assert_macros.svh"
module quaternion_normalize_continuity_unit import qnc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [4*IN_W-1:0]  s_tdata,   // in_x, in_y, in_z, in_w
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [4*OUT_W-1:0] m_tdata,   // out_x, out_y, out_z, out_w
    output logic              m_tuser,   // accepted
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    qnc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qnc_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_data      (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .out_data     (m_tdata),
        .out_accepted (m_tuser)
    );

    `QNC_ASSERT_NEVER(a_one_in_flight, s_tready && m_tvalid, "input open while result pending")
    `QNC_ASSERT_IMPL(a_reject_zero, m_tvalid && !m_tuser, m_tdata == '0, "rejected result not zero")
    `QNC_ASSERT_IMPL(a_w_range, m_tvalid && m_tuser,
        $signed(m_tdata[4*OUT_W-1:3*OUT_W]) <= 16384 &&
        $signed(m_tdata[4*OUT_W-1:3*OUT_W]) >= -16384, "w out of unit range")
    `QNC_ASSERT_IMPL(a_x_range, m_tvalid && m_tuser,
        $signed(m_tdata[OUT_W-1:0]) <= 16384 &&
        $signed(m_tdata[OUT_W-1:0]) >= -16384, "x out of unit range")

endmodule
